[rtl/tcw_pkg.sv]
// Shared constants and types of the text console writer.
package tcw_pkg;

    // Default screen size in character cells.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths on the stream ports.
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int COL_F_W = 7;
    localparam int ROW_F_W = 5;
    localparam int CELL_W  = 16;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;
    localparam logic [COLOR_W-1:0] SCROLL_FILL_COLOR = 8'h00;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT_CHAR = 2'd0,
        KIND_PUT_AT   = 2'd1,
        KIND_CLEAR    = 2'd2,
        KIND_READ     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_FILL,
        S_PUSH
    } t_state;

endpackage

[rtl/text_console_writer_core.sv]
// Top level of the text console writer: cursor control over a cell store in one RAM.
//
// Text console of COLUMNS by ROWS cells, held in a single-port RAM of 16-bit cells
// (attribute byte high, character byte low). Every input transaction yields exactly one
// output transaction carrying the cursor after the item, the cell read (zero unless the
// item is a read) and a scroll flag. The cell store is undefined after reset until a clear
// item has been issued. Scrolling is done by rotating a row offset, so a scroll costs only
// a refill of the freed row. All timing follows from the one RAM port: every item is
// executed in the EXEC state; a read then waits in READ for the registered RAM data, a
// character that scrolls blanks the freed row in FILL and a clear blanks every cell in
// FILL. A finished result that cannot be handed downstream waits in PUSH. The next item is
// accepted in the cycle after the result is registered, even if that result has not yet
// been taken downstream.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [COLOR_W-1:0]    i_cfg_wr_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // char_code[7:0], cell_color[15:8], column[22:16], row[27:23], zero[31:28]
    input  logic [S_DATA_W-1:0]   i_s_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]     i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // cursor_column[6:0], cursor_row[11:7], cell_value[27:12], scrolled[28], zero[31:29]
    output logic [M_DATA_W-1:0]   o_m_tdata
);

    localparam int DEPTH  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    t_state r_state, n_state;

    logic [COLOR_W-1:0] r_text_color;
    logic [COL_W-1:0]   r_cur_col, n_cur_col;
    logic [ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [ROW_W-1:0]   r_base, n_base;
    logic               r_out_valid, n_out_valid;

    t_kind              r_kind;
    logic [CHAR_W-1:0]  r_in_char;
    logic [COLOR_W-1:0] r_in_color;
    logic [COL_F_W-1:0] r_in_col;
    logic [ROW_F_W-1:0] r_in_row;

    logic [ADDR_W-1:0]  r_fill_addr, n_fill_addr;
    logic [ADDR_W-1:0]  r_fill_end, n_fill_end;
    logic [CELL_W-1:0]  r_fill_data, n_fill_data;
    logic [CELL_W-1:0]  r_value, n_value;
    logic               r_scrolled, n_scrolled;
    logic [M_DATA_W-1:0] r_out_data;

    logic               w_accept;
    logic               w_out_free;
    logic               w_in_range;
    logic               w_newline;
    logic [COL_W:0]     w_col_inc;
    logic               w_wrap;
    logic               w_last_row;
    logic               w_scroll;
    logic               w_fill_done;
    logic               w_load;
    logic [COL_W-1:0]   w_pos_col;
    logic [ROW_W-1:0]   w_pos_row;
    logic [ROW_W:0]     w_row_sum;
    logic [ROW_W:0]     w_phys_row;
    logic [ADDR_W-1:0]  w_pos_addr;
    logic [ADDR_W-1:0]  w_base_addr;

    logic               w_mem_wr_en;
    logic [ADDR_W-1:0]  w_mem_addr;
    logic [CELL_W-1:0]  w_mem_wr_data;
    logic [CELL_W-1:0]  w_mem_rd_data;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr_en),
        .i_addr    (w_mem_addr),
        .i_wr_data (w_mem_wr_data),
        .o_rd_data (w_mem_rd_data)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_in_range = (32'(r_in_col) < COLUMNS) && (32'(r_in_row) < ROWS);
    assign w_newline  = (r_in_char == NEWLINE_CODE);
    assign w_col_inc  = {1'b0, r_cur_col} + (COL_W+1)'(1);
    assign w_wrap     = w_newline || (32'(w_col_inc) >= COLUMNS);
    assign w_last_row = (32'(r_cur_row) == ROWS - 1);
    assign w_scroll   = w_wrap && w_last_row;
    assign w_fill_done = (r_fill_addr == r_fill_end);

    // Logical row to physical row through the rotating row offset.
    assign w_pos_col  = (r_kind == KIND_PUT_CHAR) ? r_cur_col : COL_W'(r_in_col);
    assign w_pos_row  = (r_kind == KIND_PUT_CHAR) ? r_cur_row : ROW_W'(r_in_row);
    assign w_row_sum  = {1'b0, w_pos_row} + {1'b0, r_base};
    assign w_phys_row = (32'(w_row_sum) >= ROWS) ? w_row_sum - (ROW_W+1)'(ROWS) : w_row_sum;
    assign w_pos_addr = ADDR_W'(w_phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(w_pos_col);
    assign w_base_addr = ADDR_W'(r_base) * ADDR_W'(COLUMNS);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_kind)
                    KIND_PUT_CHAR: begin
                        if (w_scroll) begin
                            n_state = S_FILL;
                        end else begin
                            n_state = w_out_free ? S_IDLE : S_PUSH;
                        end
                    end
                    KIND_PUT_AT: begin
                        n_state = w_out_free ? S_IDLE : S_PUSH;
                    end
                    KIND_CLEAR: begin
                        n_state = S_FILL;
                    end
                    KIND_READ: begin
                        if (w_in_range) begin
                            n_state = S_READ;
                        end else begin
                            n_state = w_out_free ? S_IDLE : S_PUSH;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_READ: begin
                n_state = w_out_free ? S_IDLE : S_PUSH;
            end
            S_FILL: begin
                if (w_fill_done) begin
                    n_state = w_out_free ? S_IDLE : S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_cur_col     = r_cur_col;
        n_cur_row     = r_cur_row;
        n_base        = r_base;
        n_fill_addr   = r_fill_addr;
        n_fill_end    = r_fill_end;
        n_fill_data   = r_fill_data;
        n_value       = r_value;
        n_scrolled    = r_scrolled;
        w_mem_wr_en   = 1'b0;
        w_mem_addr    = w_pos_addr;
        w_mem_wr_data = {r_in_color, r_in_char};

        unique case (r_state)
            S_EXEC: begin
                n_value    = '0;
                n_scrolled = 1'b0;
                unique case (r_kind)
                    KIND_PUT_CHAR: begin
                        w_mem_wr_en   = !w_newline;
                        w_mem_wr_data = {r_text_color, r_in_char};
                        if (w_wrap) begin
                            n_cur_col = '0;
                            if (!w_last_row) begin
                                n_cur_row = r_cur_row + ROW_W'(1);
                            end
                        end else begin
                            n_cur_col = w_col_inc[COL_W-1:0];
                        end
                        // The old top row becomes the bottom row and is blanked.
                        if (w_scroll) begin
                            n_scrolled  = 1'b1;
                            n_base      = (32'(r_base) == ROWS - 1) ? '0 : r_base + ROW_W'(1);
                            n_fill_addr = w_base_addr;
                            n_fill_end  = w_base_addr + ADDR_W'(COLUMNS - 1);
                            n_fill_data = {SCROLL_FILL_COLOR, SPACE_CODE};
                        end
                    end
                    KIND_PUT_AT: begin
                        w_mem_wr_en = w_in_range;
                    end
                    KIND_CLEAR: begin
                        n_cur_col   = '0;
                        n_cur_row   = '0;
                        n_base      = '0;
                        n_fill_addr = '0;
                        n_fill_end  = ADDR_W'(DEPTH - 1);
                        n_fill_data = {r_text_color, SPACE_CODE};
                    end
                    KIND_READ: begin
                        w_mem_wr_en = 1'b0;
                    end
                    default: w_mem_wr_en = 1'b0;
                endcase
            end
            S_READ: begin
                n_value = w_mem_rd_data;
            end
            S_FILL: begin
                w_mem_wr_en   = 1'b1;
                w_mem_addr    = r_fill_addr;
                w_mem_wr_data = r_fill_data;
                if (!w_fill_done) begin
                    n_fill_addr = r_fill_addr + ADDR_W'(1);
                end
            end
            default: begin
                w_mem_wr_en = 1'b0;
            end
        endcase
    end

    // The result is registered as the block returns to idle, after any wait in PUSH.
    assign w_load = (r_state != S_IDLE) && (n_state == S_IDLE);

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_text_color <= TEXT_COLOR_RESET;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_base       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_text_color <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind     <= t_kind'(i_s_tuser);
            r_in_char  <= i_s_tdata[7:0];
            r_in_color <= i_s_tdata[15:8];
            r_in_col   <= i_s_tdata[22:16];
            r_in_row   <= i_s_tdata[27:23];
        end
        r_fill_addr <= n_fill_addr;
        r_fill_end  <= n_fill_end;
        r_fill_data <= n_fill_data;
        r_value     <= n_value;
        r_scrolled  <= n_scrolled;
        if (w_load) begin
            r_out_data <= {3'b000, n_scrolled, n_value,
                           ROW_F_W'(n_cur_row), COL_F_W'(n_cur_col)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[rtl/tcw_ram.sv]
// Generic single-port RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[tb/sv/tb_text_console_writer_core.sv]
// Self-checking testbench for the text console writer core.
`timescale 1ns / 1ps

module tb_text_console_writer_core;
    import tcw_pkg::*;

    localparam int COLS  = COLUMNS_DEF;
    localparam int LINES = ROWS_DEF;
    localparam int CELLS = COLS * LINES;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int PHASES = 8;

    typedef struct {
        t_kind               kind;
        logic [CHAR_W-1:0]   char_code;
        logic [COLOR_W-1:0]  cell_color;
        logic [COL_F_W-1:0]  column;
        logic [ROW_F_W-1:0]  row;
    } t_console_item;

    typedef struct {
        logic [COL_F_W-1:0]  cursor_column;
        logic [ROW_F_W-1:0]  cursor_row;
        logic [CELL_W-1:0]   cell_value;
        logic                scrolled;
    } t_console_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [COLOR_W-1:0]    i_cfg_wr_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // char_code[7:0], cell_color[15:8], column[22:16], row[27:23], zero[31:28]
    logic [S_DATA_W-1:0]   i_s_tdata = '0;
    // kind[1:0]
    logic [KIND_W-1:0]     i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // cursor_column[6:0], cursor_row[11:7], cell_value[27:12], scrolled[28], zero[31:29]
    logic [M_DATA_W-1:0]   o_m_tdata;

    text_console_writer_core #(
        .COLUMNS(COLS),
        .ROWS(LINES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the console: cell store, cursor and attribute register.
    logic [CELL_W-1:0]   shadow_cells [0:CELLS-1];
    int unsigned         shadow_col;
    int unsigned         shadow_line;
    logic [COLOR_W-1:0]  shadow_color = TEXT_COLOR_RESET;

    t_console_item       pending_items [$];
    t_console_result     expected_results [$];
    int unsigned         mismatch_count = 0;
    int unsigned         src_idle_pct = 0;
    int unsigned         snk_idle_pct = 0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("tb: mismatch on %s: got 0x%0h, expected 0x%0h at %0t",
                 what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic t_console_result console_apply(input t_console_item it);
        t_console_result res;
        bit              in_range;
        bit              is_newline;
        res.cell_value = '0;
        res.scrolled   = 1'b0;
        in_range = (32'(it.column) < COLS) && (32'(it.row) < LINES);
        case (it.kind)
            KIND_PUT_CHAR: begin
                is_newline = (it.char_code == NEWLINE_CODE);
                if (!is_newline)
                    shadow_cells[CELL_AW'(shadow_line * COLS + shadow_col)] =
                        {shadow_color, it.char_code};
                shadow_col++;
                if (shadow_col >= COLS || is_newline) begin
                    shadow_col = 0;
                    shadow_line++;
                    if (shadow_line >= LINES) begin
                        // Every row moves up one and the freed bottom row is blanked.
                        shadow_line = LINES - 1;
                        for (int i = 0; i < CELLS - COLS; i++)
                            shadow_cells[CELL_AW'(i)] = shadow_cells[CELL_AW'(i + COLS)];
                        for (int i = CELLS - COLS; i < CELLS; i++)
                            shadow_cells[CELL_AW'(i)] = {SCROLL_FILL_COLOR, SPACE_CODE};
                        res.scrolled = 1'b1;
                    end
                end
            end
            KIND_PUT_AT: begin
                if (in_range)
                    shadow_cells[CELL_AW'(32'(it.row) * COLS + 32'(it.column))] =
                        {it.cell_color, it.char_code};
            end
            KIND_CLEAR: begin
                shadow_col  = 0;
                shadow_line = 0;
                for (int i = 0; i < CELLS; i++)
                    shadow_cells[CELL_AW'(i)] = {shadow_color, SPACE_CODE};
            end
            default: begin
                if (in_range)
                    res.cell_value =
                        shadow_cells[CELL_AW'(32'(it.row) * COLS + 32'(it.column))];
            end
        endcase
        res.cursor_column = shadow_col[COL_F_W-1:0];
        res.cursor_row    = shadow_line[ROW_F_W-1:0];
        return res;
    endfunction

    function automatic t_console_item make_item(input t_kind kind, input int unsigned ch,
                                                input int unsigned color,
                                                input int unsigned col,
                                                input int unsigned row);
        t_console_item it;
        it.kind       = kind;
        it.char_code  = ch[CHAR_W-1:0];
        it.cell_color = color[COLOR_W-1:0];
        it.column     = col[COL_F_W-1:0];
        it.row        = row[ROW_F_W-1:0];
        return it;
    endfunction

    // Queues a run of mostly text, with a given newline rate, and some positioned
    // writes and reads scattered through it. Positions sometimes fall off the screen.
    task automatic queue_text_run(input int n, input int unsigned nl_div);
        int unsigned   pick;
        int unsigned   ch;
        int unsigned   col;
        int unsigned   row;
        t_console_item it;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            ch   = ($urandom_range(0, nl_div) == 0) ? 32'(NEWLINE_CODE)
                                                     : $urandom_range(0, 255);
            if ($urandom_range(0, 99) < 87) begin
                col = $urandom_range(0, COLS - 1);
                row = $urandom_range(0, LINES - 1);
            end else begin
                col = $urandom_range(0, 127);
                row = $urandom_range(0, 31);
            end
            if (pick < 70)
                it = make_item(KIND_PUT_CHAR, ch, $urandom_range(0, 255),
                               $urandom_range(0, 127), $urandom_range(0, 31));
            else if (pick < 83)
                it = make_item(KIND_PUT_AT, $urandom_range(0, 255), $urandom_range(0, 255),
                               col, row);
            else
                it = make_item(KIND_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                               col, row);
            pending_items.push_back(it);
        end
    endtask

    task automatic wait_until_idle();
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || i_s_tvalid || expected_results.size() != 0);
    endtask

    // Driver: presents queued items and predicts each one as its transaction completes.
    t_console_item drv_item;
    int unsigned   src_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_results.push_back(console_apply(drv_item));
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0 &&
                             $urandom_range(0, 99) < src_idle_pct) begin
                    src_gap = $urandom_range(1, 8) - 1;
                    i_s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    drv_item = pending_items.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {4'b0, drv_item.row, drv_item.column,
                                   drv_item.cell_color, drv_item.char_code};
                    i_s_tuser  <= drv_item.kind;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result transaction against the oldest prediction.
    t_console_result want;
    int unsigned     snk_stall = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none expected", o_m_tdata, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tdata[6:0] !== want.cursor_column)
                        report_mismatch("cursor_column", 32'(o_m_tdata[6:0]),
                                        32'(want.cursor_column));
                    if (o_m_tdata[11:7] !== want.cursor_row)
                        report_mismatch("cursor_row", 32'(o_m_tdata[11:7]),
                                        32'(want.cursor_row));
                    if (o_m_tdata[27:12] !== want.cell_value)
                        report_mismatch("cell_value", 32'(o_m_tdata[27:12]),
                                        32'(want.cell_value));
                    if (o_m_tdata[28] !== want.scrolled)
                        report_mismatch("scrolled", 32'(o_m_tdata[28]), 32'(want.scrolled));
                end
            end
            if (snk_stall > 0) begin
                snk_stall--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < snk_idle_pct) begin
                snk_stall = $urandom_range(1, 8) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [COLOR_W-1:0] phase_color [PHASES];
        int unsigned        phase_nl_div [PHASES];
        int unsigned        phase_src_pct [PHASES];
        int unsigned        phase_snk_pct [PHASES];
        phase_color   = '{8'hFF, 8'h00, 8'h00, 8'h80, 8'h00, 8'h01, 8'h00, 8'hFF};
        phase_nl_div  = '{3, 60, 4, 2, 100, 5, 3, 8};
        phase_src_pct = '{20, 10, 0, 30, 15, 25, 0, 0};
        phase_snk_pct = '{20, 30, 25, 0, 10, 35, 0, 0};
        phase_color[2] = COLOR_W'($urandom_range(0, 255));
        phase_color[4] = COLOR_W'($urandom_range(0, 255));
        phase_color[6] = COLOR_W'($urandom_range(0, 255));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items under the reset attribute. The first clear defines every cell.
        src_idle_pct = 25;
        snk_idle_pct = 25;
        pending_items.push_back(make_item(KIND_CLEAR, 0, 0, 0, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, COLS - 1, LINES - 1));
        pending_items.push_back(make_item(KIND_PUT_CHAR, 'h41, 0, 0, 0));
        pending_items.push_back(make_item(KIND_PUT_CHAR, 0, 'hFF, 127, 31));
        pending_items.push_back(make_item(KIND_PUT_CHAR, 'hFF, 0, 0, 0));
        // A newline moves the cursor without writing a cell.
        pending_items.push_back(make_item(KIND_PUT_CHAR, 32'(NEWLINE_CODE), 0, 0, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 1, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 3, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, 1));
        pending_items.push_back(make_item(KIND_PUT_AT, 'hFF, 'hFF, COLS - 1, LINES - 1));
        pending_items.push_back(make_item(KIND_READ, 'hFF, 'hFF, COLS - 1, LINES - 1));
        pending_items.push_back(make_item(KIND_PUT_AT, 0, 0, 0, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, 0));
        // Positions off the screen are ignored by writes and read back as zero.
        pending_items.push_back(make_item(KIND_PUT_AT, 'h55, 'hAA, COLS, 0));
        pending_items.push_back(make_item(KIND_PUT_AT, 'h55, 'hAA, 0, LINES));
        pending_items.push_back(make_item(KIND_PUT_AT, 'h55, 'hAA, 127, 31));
        pending_items.push_back(make_item(KIND_READ, 0, 0, COLS, 0));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 0, LINES));
        pending_items.push_back(make_item(KIND_READ, 0, 0, 127, 31));

        for (int p = 0; p < PHASES; p++) begin
            wait_until_idle();
            repeat (4) @(posedge i_clk);
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= phase_color[p];
            @(posedge i_clk);
            i_cfg_wr_en  <= 1'b0;
            shadow_color = phase_color[p];
            @(negedge i_clk);
            src_idle_pct = phase_src_pct[p];
            snk_idle_pct = phase_snk_pct[p];
            if (p % 3 == 0)
                pending_items.push_back(make_item(KIND_CLEAR, $urandom_range(0, 255),
                                                  $urandom_range(0, 255),
                                                  $urandom_range(0, 127),
                                                  $urandom_range(0, 31)));
            queue_text_run(116, phase_nl_div[p]);
        end

        wait_until_idle();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
